// ----- rtl/epoch_days_to_year_day_month_top_defines.svh -----
// Assertion macros for the day-count-to-date block.
// Used by files that take ed2ymd_pkg and sample on clk with rst_n.
`ifndef EPOCH_DAYS_TO_YEAR_DAY_MONTH_TOP_DEFINES_SVH
`define EPOCH_DAYS_TO_YEAR_DAY_MONTH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ED2YMD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ED2YMD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ed2ymd_pkg.sv -----
// Shared constants, types and month table for the day-count-to-date pipeline.
// No dependencies.
`default_nettype none

package ed2ymd_pkg;

    localparam logic [21:0] LAST_DAY  = 22'd3652424;
    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [15:0] DAYS_100Y = 16'd36524;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;
    localparam logic [8:0]  DAYS_YEAR = 9'd365;
    localparam logic [8:0]  DAYS_LEAP = 9'd366;
    localparam logic [13:0] MAX_YEAR  = 14'd9999;
    localparam logic [8:0]  MAX_DOY   = 9'd365;
    localparam logic [3:0]  LAST_MONTH = 4'd11;

    // Reciprocals for division by constants: quotient estimate is exact or one low.
    localparam int DIV400_SHIFT = 40;
    localparam logic [22:0] DIV400_RECIP = 23'((64'd1 << DIV400_SHIFT) / 64'd146097);
    localparam int DIV4Y_SHIFT = 24;
    localparam logic [13:0] DIV4Y_RECIP = 14'((64'd1 << DIV4Y_SHIFT) / 64'd1461);

    localparam logic [8:0] MSTART_REG [0:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] MSTART_LEAP [0:12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    // Result of the 400- and 100-year split.
    typedef struct packed {
        logic        sat;    // count at or past LAST_DAY, the last representable day
        logic        first;  // first year of a 400-year cycle
        logic [6:0]  cent;   // whole centuries
        logic [15:0] rem;    // day within the cycle or century
    } cyc_t;

    typedef struct packed {
        logic [13:0] year;
        logic [8:0]  doy;
        logic        leap;
    } date_t;

    function automatic logic [3:0] month_of(input logic [8:0] doy, input logic leap);
        logic [3:0] m;
        m = '0;
        for (int i = 1; i < 13; i++) begin
            if ((leap ? MSTART_LEAP[i] : MSTART_REG[i]) <= doy) begin
                m = m + 4'd1;
            end
        end
        if (m > LAST_MONTH) begin
            m = LAST_MONTH;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/epoch_days_to_year_day_month_top.sv -----
// Day count since 1 January of year 0 to year, day of year, month and leap flag.
// Throughput: one item per cycle while date_stall is low; every stage holds its own
// valid bit, so bubbles close up.
// Reset: rst_n clears all valid bits asynchronously; payload registers are not reset.
// Depends on ed2ymd_pkg, ed2ymd_cycle, ed2ymd_group, ed2ymd_month and the defines header.
`default_nettype none

`include "epoch_days_to_year_day_month_top_defines.svh"

module epoch_days_to_year_day_month_top
    import ed2ymd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        day_valid,
    output logic             day_stall,
    input  wire logic [21:0] day_number,
    output logic             date_valid,
    input  wire logic        date_stall,
    output logic [13:0]      year,
    output logic [8:0]       day_of_year,
    output logic [3:0]       month,
    output logic             leap_year
);

    // Item flow: cycle split (3 stages) -> group split (3 stages) -> month and output.
    logic  cyc_valid;
    logic  cyc_stall;
    cyc_t  cyc;
    logic  grp_valid;
    logic  grp_stall;
    date_t grp_date;

    // Split off 400-year cycles and centuries; flag saturating counts.
    ed2ymd_cycle u_cycle (
        .clk        (clk),
        .rst_n      (rst_n),
        .day_valid  (day_valid),
        .day_stall  (day_stall),
        .day_number (day_number),
        .cyc_valid  (cyc_valid),
        .cyc_stall  (cyc_stall),
        .cyc        (cyc)
    );

    // Split the century into 4-year groups and years; build year, day and leap flag.
    ed2ymd_group u_group (
        .clk        (clk),
        .rst_n      (rst_n),
        .cyc_valid  (cyc_valid),
        .cyc_stall  (cyc_stall),
        .cyc        (cyc),
        .date_valid (grp_valid),
        .date_stall (grp_stall),
        .date       (grp_date)
    );

    // Look up the month and hold the item in the output register.
    ed2ymd_month u_month (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_valid  (grp_valid),
        .date_stall  (grp_stall),
        .date        (grp_date),
        .out_valid   (date_valid),
        .out_stall   (date_stall),
        .year        (year),
        .day_of_year (day_of_year),
        .month       (month),
        .leap_year   (leap_year)
    );

    // A leap year is always a multiple of four.
    `ED2YMD_ASSERT_IMP(a_leap_div4, date_valid && leap_year, year[1:0] == 2'b00,
        "leap flag on a year that is not a multiple of four")

    // Day 365 of a regular year only comes from saturation.
    `ED2YMD_ASSERT_IMP(a_doy_range, date_valid && !leap_year && (day_of_year == MAX_DOY),
        year == MAX_YEAR, "day 365 in a regular year below the saturation year")

    // December starts no earlier than day 334.
    `ED2YMD_ASSERT_IMP(a_month_dec, date_valid && (month == LAST_MONTH),
        day_of_year >= 9'd334, "December reported before its first day")

    // Year and month stay within range.
    `ED2YMD_ASSERT_IMP(a_year_range, date_valid,
        (year <= MAX_YEAR) && (month <= LAST_MONTH),
        "year or month out of range")

    // Hold a stalled result and its payload until it is taken.
    `ED2YMD_ASSERT_NXT(a_out_hold, date_valid && date_stall,
        date_valid && $stable({year, day_of_year, month, leap_year}),
        "stalled result changed before it was taken")

endmodule

`default_nettype wire

// ----- rtl/ed2ymd_cycle.sv -----
// Stages 1-3: split the day count into 400-year cycles and centuries.
// Depends on ed2ymd_pkg.
`default_nettype none

module ed2ymd_cycle
    import ed2ymd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        day_valid,
    output logic             day_stall,
    input  wire logic [21:0] day_number,
    output logic             cyc_valid,
    input  wire logic        cyc_stall,
    output cyc_t             cyc
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [21:0] s1_d_reg,  s1_d_next;
    logic        s1_sat_reg, s1_sat_next;
    logic [4:0]  s1_qe_reg, s1_qe_next;
    logic [44:0] s1_prod;

    logic [4:0]  s2_q_reg, s2_q_next;
    logic [17:0] s2_r_reg, s2_r_next;
    logic        s2_sat_reg;
    logic [22:0] s2_diff;
    logic [18:0] s2_r0;
    logic        s2_corr;

    cyc_t        s3_reg, s3_next;
    logic        s3_first;
    logic [17:0] s3_d1;
    logic [1:0]  s3_c100;
    logic [17:0] s3_r100;

    assign en3 = !v3_reg || !cyc_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign day_stall = !en1;
    assign cyc_valid = v3_reg;
    assign cyc = s3_reg;

    // Stage 1: estimate the 400-year quotient by reciprocal multiply.
    assign s1_prod     = 45'(day_number) * 45'(DIV400_RECIP);
    assign s1_qe_next  = s1_prod[DIV400_SHIFT +: 5];
    assign s1_d_next   = day_number;
    assign s1_sat_next = day_number >= LAST_DAY;

    // Stage 2: remainder and one-step correction.
    assign s2_diff   = {1'b0, s1_d_reg} - (23'(s1_qe_reg) * 23'(DAYS_400Y));
    assign s2_r0     = s2_diff[18:0];
    assign s2_corr   = s2_r0 >= 19'(DAYS_400Y);
    assign s2_q_next = s1_qe_reg + 5'(s2_corr);
    assign s2_r_next = s2_corr ? 18'(s2_r0 - 19'(DAYS_400Y)) : s2_r0[17:0];

    // Stage 3: century split; the first cycle year holds one extra day.
    always_comb
    begin
        s3_first = s2_r_reg < 18'(DAYS_LEAP);
        s3_d1    = s2_r_reg - 18'd1;
        if (s3_d1 >= 18'(3 * DAYS_100Y)) begin
            s3_c100 = 2'd3;
        end else if (s3_d1 >= 18'(2 * DAYS_100Y)) begin
            s3_c100 = 2'd2;
        end else if (s3_d1 >= 18'(DAYS_100Y)) begin
            s3_c100 = 2'd1;
        end else begin
            s3_c100 = 2'd0;
        end
        s3_r100 = s3_d1 - (18'(s3_c100) * 18'(DAYS_100Y));
        s3_next.sat   = s2_sat_reg;
        s3_next.first = s3_first;
        s3_next.cent  = {s2_q_reg, 2'b00} + (s3_first ? 7'd0 : 7'(s3_c100));
        s3_next.rem   = s3_first ? s2_r_reg[15:0] : s3_r100[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= day_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            s1_d_reg   <= s1_d_next;
            s1_sat_reg <= s1_sat_next;
            s1_qe_reg  <= s1_qe_next;
        end
        if (en2) begin
            s2_q_reg   <= s2_q_next;
            s2_r_reg   <= s2_r_next;
            s2_sat_reg <= s1_sat_reg;
        end
        if (en3) begin
            s3_reg <= s3_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ed2ymd_group.sv -----
// Stages 4-6: split a century into 4-year groups and years, form year and day.
// Depends on ed2ymd_pkg.
`default_nettype none

module ed2ymd_group
    import ed2ymd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cyc_valid,
    output logic       cyc_stall,
    input  wire cyc_t  cyc,
    output logic       date_valid,
    input  wire logic  date_stall,
    output date_t      date
);

    logic v4_reg, v5_reg, v6_reg;
    logic en4, en5, en6;

    cyc_t        s4_cyc_reg;
    logic [15:0] s4_d2_reg, s4_d2_next;
    logic [4:0]  s4_qe_reg, s4_qe_next;
    logic [29:0] s4_prod;

    cyc_t        s5_cyc_reg;
    logic [4:0]  s5_c4_reg, s5_c4_next;
    logic [10:0] s5_r4_reg, s5_r4_next;
    logic [15:0] s5_diff;
    logic [11:0] s5_r0;
    logic        s5_corr;

    date_t       s6_reg, s6_next;
    logic        s6_four;
    logic        s6_long;
    logic [10:0] s6_d3;
    logic [1:0]  s6_y1;
    logic [10:0] s6_doy4;
    logic [13:0] s6_base;

    assign en6 = !v6_reg || !date_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign cyc_stall  = !en4;
    assign date_valid = v6_reg;
    assign date       = s6_reg;

    // Stage 4: shift the day back into the 4-year frame, estimate the group.
    assign s4_d2_next = cyc.rem + 16'd1;
    assign s4_prod    = 30'(s4_d2_next) * 30'(DIV4Y_RECIP);
    assign s4_qe_next = s4_prod[DIV4Y_SHIFT +: 5];

    // Stage 5: remainder and one-step correction.
    assign s5_diff    = s4_d2_reg - (16'(s4_qe_reg) * 16'(DAYS_4Y));
    assign s5_r0      = s5_diff[11:0];
    assign s5_corr    = s5_r0 >= 12'(DAYS_4Y);
    assign s5_c4_next = s4_qe_reg + 5'(s5_corr);
    assign s5_r4_next = s5_corr ? 11'(s5_r0 - 12'(DAYS_4Y)) : s5_r0[10:0];

    // Stage 6: year within the group, then pick the path and saturate.
    always_comb
    begin
        s6_four = !s5_cyc_reg.first && (s5_cyc_reg.rem >= 16'(DAYS_YEAR));
        s6_long = s5_r4_reg >= 11'(DAYS_LEAP);
        s6_d3   = s6_long ? (s5_r4_reg - 11'd1) : s5_r4_reg;
        if (!s6_long) begin
            s6_y1 = 2'd0;
        end else if (s6_d3 >= 11'(3 * DAYS_YEAR)) begin
            s6_y1 = 2'd3;
        end else if (s6_d3 >= 11'(2 * DAYS_YEAR)) begin
            s6_y1 = 2'd2;
        end else begin
            s6_y1 = 2'd1;
        end
        s6_doy4 = s6_d3 - (11'(s6_y1) * 11'(DAYS_YEAR));
        s6_base = 14'(s5_cyc_reg.cent) * 14'd100;

        if (s5_cyc_reg.sat) begin
            s6_next.year = MAX_YEAR;
            s6_next.doy  = MAX_DOY;
            s6_next.leap = 1'b0;
        end else if (s6_four) begin
            s6_next.year = s6_base + 14'({s5_c4_reg, 2'b00}) + 14'(s6_y1);
            s6_next.doy  = s6_doy4[8:0];
            s6_next.leap = !s6_long;
        end else begin
            // First year of a cycle is leap; first year of a later century is not.
            s6_next.year = s6_base;
            s6_next.doy  = s5_cyc_reg.rem[8:0];
            s6_next.leap = s5_cyc_reg.first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en4) begin
                v4_reg <= cyc_valid;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
            if (en6) begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4) begin
            s4_cyc_reg <= cyc;
            s4_d2_reg  <= s4_d2_next;
            s4_qe_reg  <= s4_qe_next;
        end
        if (en5) begin
            s5_cyc_reg <= s4_cyc_reg;
            s5_c4_reg  <= s5_c4_next;
            s5_r4_reg  <= s5_r4_next;
        end
        if (en6) begin
            s6_reg <= s6_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ed2ymd_month.sv -----
// Stage 7: month lookup and the output register.
// Depends on ed2ymd_pkg.
`default_nettype none

module ed2ymd_month
    import ed2ymd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  date_valid,
    output logic       date_stall,
    input  wire date_t date,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [13:0] year,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month,
    output logic        leap_year
);

    logic        v7_reg;
    logic        en7;
    date_t       s7_date_reg;
    logic [3:0]  s7_month_reg, s7_month_next;

    assign en7        = !v7_reg || !out_stall;
    assign date_stall = !en7;
    assign out_valid  = v7_reg;

    assign s7_month_next = month_of(date.doy, date.leap);

    assign year        = s7_date_reg.year;
    assign day_of_year = s7_date_reg.doy;
    assign leap_year   = s7_date_reg.leap;
    assign month       = s7_month_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v7_reg <= 1'b0;
        end else if (en7) begin
            v7_reg <= date_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en7) begin
            s7_date_reg  <= date;
            s7_month_reg <= s7_month_next;
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for epoch_days_to_year_day_month_top: day counts in, dates out.
// Depends on ed2ymd_pkg for the calendar constants and the month-start tables.
`timescale 1ns / 1ps

module testbench;
    import ed2ymd_pkg::*;

    localparam int          HOLDOFF_CYCLES = 300;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [21:0] MAX_COUNT      = 22'h3FFFFF;

    // Expected output of one conversion, one member per result port.
    typedef struct packed {
        logic [13:0] yr;
        logic [8:0]  doy;
        logic [3:0]  mon;
        logic        leap;
    } calendar_date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        day_valid = 1'b0;
    logic        day_stall;
    logic [21:0] day_number = '0;
    logic        date_valid;
    logic        date_stall = 1'b0;
    logic [13:0] year;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic        leap_year;

    // Day counts waiting to be offered, and dates waiting to come out.
    logic [21:0]    pending_days[$];
    calendar_date_t expected_dates[$];

    // Idle odds in percent, changed per phase from the stimulus process.
    int unsigned sender_idle_pct = 38;
    int unsigned recv_idle_pct   = 73;
    logic        holdoff_go = 1'b0;
    int unsigned holdoff_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    epoch_days_to_year_day_month_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .day_valid   (day_valid),
        .day_stall   (day_stall),
        .day_number  (day_number),
        .date_valid  (date_valid),
        .date_stall  (date_stall),
        .year        (year),
        .day_of_year (day_of_year),
        .month       (month),
        .leap_year   (leap_year)
    );

    always #5 clk = ~clk;

    // Split a day count into 400-, 100-, 4- and 1-year cycles, then look up the month.
    function automatic calendar_date_t days_to_date(input logic [21:0] count);
        int unsigned    rest;
        int unsigned    cyc;
        int unsigned    cent;
        int unsigned    quad;
        int unsigned    yr;
        int unsigned    doy;
        logic           lp;
        logic [3:0]     mon;
        calendar_date_t r;
        rest = count;
        if (rest == 0) begin
            yr  = 0;
            doy = 0;
        end else if (rest >= LAST_DAY) begin
            yr  = MAX_YEAR;
            doy = MAX_DOY;
        end else begin
            cyc  = rest / DAYS_400Y;
            rest = rest % DAYS_400Y;
            if (rest < DAYS_LEAP) begin
                // First year of a 400-year cycle is always a leap year.
                yr  = cyc * 400;
                doy = rest;
            end else if (cyc >= 25) begin
                yr  = MAX_YEAR;
                doy = MAX_DOY;
            end else begin
                rest = rest - 1;
                cent = rest / DAYS_100Y;
                rest = rest % DAYS_100Y;
                if (rest < DAYS_YEAR) begin
                    // First year of a century other than the cycle start: not leap.
                    yr  = cyc * 400 + cent * 100;
                    doy = rest;
                end else begin
                    rest = rest + 1;
                    quad = rest / DAYS_4Y;
                    rest = rest % DAYS_4Y;
                    yr   = cyc * 400 + cent * 100 + quad * 4;
                    if (rest >= DAYS_LEAP) begin
                        rest = rest - 1;
                        yr   = yr + rest / DAYS_YEAR;
                        rest = rest % DAYS_YEAR;
                    end
                    doy = rest;
                end
            end
        end
        lp  = ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
        mon = '0;
        for (int i = 1; i < 13; i++) begin
            if ((lp ? MSTART_LEAP[i] : MSTART_REG[i]) <= doy) begin
                mon = 4'(i);
            end
        end
        // Day 365 of a regular year would land on month 12; clamp to December.
        if (mon > LAST_MONTH) begin
            mon = LAST_MONTH;
        end
        r.yr   = 14'(yr);
        r.doy  = 9'(doy);
        r.mon  = mon;
        r.leap = lp;
        return r;
    endfunction

    // Draw one random day count; most land in the calendar range, many near cycle edges.
    function automatic logic [21:0] random_day_count();
        int          pick;
        int          base;
        logic [21:0] v;
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
            v = 22'($urandom_range(LAST_DAY - 1, 1));
        end else if (pick < 70) begin
            base = $urandom_range(24, 0) * DAYS_400Y + $urandom_range(3, 0) * DAYS_100Y
                 + $urandom_range(24, 0) * DAYS_4Y + $urandom_range(3, 0) * DAYS_YEAR
                 + $urandom_range(2, 0) + $urandom_range(6, 0) - 3;
            if (base < 0) begin
                base = 0;
            end
            v = 22'(base);
        end else if (pick < 85) begin
            v = 22'($urandom_range(MAX_COUNT, 0));
        end else begin
            v = 22'($urandom_range(LAST_DAY + 800, LAST_DAY - 800));
        end
        return v;
    endfunction

    // Driver: retire the offered item on acceptance, then offer the next one or idle.
    // A stalled item keeps its valid and payload untouched.
    always @(posedge clk) begin
        logic        taken;
        logic        offer;
        logic [21:0] next_count;
        if (!rst_n) begin
            day_valid  <= 1'b0;
            day_number <= '0;
        end else begin
            taken = day_valid && !day_stall;
            if (taken) begin
                expected_dates.push_back(days_to_date(day_number));
            end
            if (!day_valid || taken) begin
                offer = (pending_days.size() != 0)
                     && ($urandom_range(99, 0) >= sender_idle_pct);
                if (offer) begin
                    next_count = pending_days.pop_front();
                    day_number <= next_count;
                end
                day_valid <= offer;
            end
        end
    end

    // Long receiver hold-off, counted down in its own process.
    always @(posedge clk) begin
        if (!rst_n) begin
            holdoff_left <= 0;
        end else if (holdoff_go) begin
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Monitor: compare each accepted date with the oldest expectation, then pick the stall.
    always @(posedge clk) begin
        calendar_date_t want;
        logic           bad;
        if (!rst_n) begin
            date_stall <= 1'b0;
        end else begin
            if (date_valid && !date_stall) begin
                if (expected_dates.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected date: year %0d day %0d month %0d leap %0d",
                                 year, day_of_year, month, leap_year);
                    end
                end else begin
                    want = expected_dates.pop_front();
                    bad  = (year !== want.yr) || (day_of_year !== want.doy)
                        || (month !== want.mon) || (leap_year !== want.leap);
                    if (bad) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("date mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.yr, want.doy, want.mon, want.leap,
                                     year, day_of_year, month, leap_year);
                        end
                    end
                end
            end
            date_stall <= (holdoff_left != 0) || ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        // Directed counts: extremes, cycle and century edges, leap days, saturation.
        pending_days.push_back(22'd0);
        pending_days.push_back(22'd1);
        pending_days.push_back(22'd59);
        pending_days.push_back(22'd60);
        pending_days.push_back(22'd365);
        pending_days.push_back(22'd366);
        pending_days.push_back(22'd730);
        pending_days.push_back(22'd1461);
        pending_days.push_back(22'd1461 + 22'd59);
        pending_days.push_back(22'd36524);
        pending_days.push_back(22'd36525);
        pending_days.push_back(22'd36525 + 22'd364);
        pending_days.push_back(22'd146096);
        pending_days.push_back(22'd146097);
        pending_days.push_back(22'd146097 + 22'd365);
        pending_days.push_back(22'd146097 + 22'd366);
        pending_days.push_back(22'd693961);
        pending_days.push_back(22'd730485);
        pending_days.push_back(22'd730485 + 22'd59);
        pending_days.push_back(22'd3652059);
        pending_days.push_back(22'd3652423);
        pending_days.push_back(22'd3652424);
        pending_days.push_back(22'd3652425);
        pending_days.push_back(22'h2AAAAA);
        pending_days.push_back(MAX_COUNT);
        repeat (700) pending_days.push_back(random_day_count());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Hold off the receiver while the sender keeps offering, so the pipeline backs up.
        repeat (40) @(posedge clk);
        holdoff_go <= 1'b1;
        @(posedge clk);
        holdoff_go <= 1'b0;

        while (pending_days.size() != 0 || day_valid) @(posedge clk);
        sender_idle_pct <= 73;
        recv_idle_pct   <= 38;
        repeat (700) pending_days.push_back(random_day_count());

        while (pending_days.size() != 0 || day_valid) @(posedge clk);
        sender_idle_pct <= 0;
        recv_idle_pct   <= 0;
        repeat (600) pending_days.push_back(random_day_count());

        while (pending_days.size() != 0 || day_valid) @(posedge clk);
        while (expected_dates.size() != 0) @(posedge clk);
        // Let stray results surface after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_dates.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
